// ===== hdl/sio_cfg_pkg.sv =====
// Shared types, register codes and power-on defaults of the Super I/O configuration block.
package sio_cfg_pkg;

    localparam int NUM_GLOBAL_REGS = 48;
    localparam int REGS_PER_DEVICE = 256;
    localparam int NUM_SLOTS       = 4;   // logical devices with live base/IRQ logic

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_RESP
    } ctl_state_t;

    typedef enum logic [1:0] {
        SRC_IMM,
        SRC_GLB,
        SRC_DEV
    } rd_src_t;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_DISABLE = 2'd1;
    localparam logic [1:0] EV_ENABLE  = 2'd2;

    localparam logic [7:0] UNLOCK_KEY = 8'h55;
    localparam logic [7:0] LOCK_KEY   = 8'hAA;

    localparam logic [7:0] GLB_LDN     = 8'h07;
    localparam logic [7:0] REG_ACT     = 8'h30;
    localparam logic [7:0] REG_BASE_HI = 8'h60;
    localparam logic [7:0] REG_BASE_LO = 8'h61;
    localparam logic [7:0] REG_IRQ     = 8'h70;
    localparam logic [7:0] REG_FDD_F0  = 8'hF0;
    localparam logic [7:0] REG_FDD_F1  = 8'hF1;
    localparam logic [7:0] REG_FDD_F4  = 8'hF4;
    localparam logic [7:0] REG_FDD_F5  = 8'hF5;

    localparam logic [11:0] PORT_FDC0  = 12'h3F0;
    localparam logic [11:0] PORT_FDC1  = 12'h370;
    localparam logic [11:0] PORT_LPT0  = 12'h3BC;
    localparam logic [11:0] PORT_LPT1  = 12'h378;
    localparam logic [11:0] PORT_LPT2  = 12'h278;
    localparam logic [11:0] PORT_COM0  = 12'h3F8;
    localparam logic [11:0] PORT_COM1  = 12'h2F8;
    localparam logic [11:0] PORT_COM2  = 12'h338;
    localparam logic [11:0] PORT_COM3  = 12'h3E8;
    localparam logic [11:0] PORT_COM4  = 12'h2E8;
    localparam logic [11:0] PORT_COM5  = 12'h220;
    localparam logic [11:0] PORT_COM6  = 12'h238;
    localparam logic [11:0] PORT_COM7  = 12'h2E0;
    localparam logic [11:0] PORT_COM8  = 12'h228;

    // Power-on value of a device register.
    function automatic logic [7:0] dev_default(input logic [3:0] dev, input logic [7:0] r);
        logic [7:0] v;
        v = 8'h00;
        case ({dev, r})
            12'h030: v = 8'h01;
            12'h060: v = 8'h03;
            12'h061: v = 8'hF0;
            12'h070: v = 8'h06;
            12'h074: v = 8'h02;
            12'h0F0: v = 8'h0E;
            12'h0F2: v = 8'hFF;
            12'h130: v = 8'h01;
            12'h160: v = 8'h01;
            12'h161: v = 8'hF0;
            12'h162: v = 8'h03;
            12'h163: v = 8'hF6;
            12'h170: v = 8'h0E;
            12'h1F0: v = 8'h0C;
            12'h230: v = 8'h01;
            12'h260: v = 8'h01;
            12'h261: v = 8'h70;
            12'h262: v = 8'h03;
            12'h263: v = 8'h76;
            12'h270: v = 8'h0F;
            12'h330: v = 8'h01;
            12'h360: v = 8'h03;
            12'h361: v = 8'h78;
            12'h370: v = 8'h07;
            12'h374: v = 8'h04;
            12'h3F0: v = 8'h3C;
            12'h430: v = 8'h01;
            12'h460: v = 8'h03;
            12'h461: v = 8'hF8;
            12'h470: v = 8'h04;
            12'h4F0: v = 8'h03;
            12'h530: v = 8'h01;
            12'h560: v = 8'h02;
            12'h561: v = 8'hF8;
            12'h570: v = 8'h03;
            12'h574: v = 8'h04;
            12'h5F1: v = 8'h02;
            12'h5F2: v = 8'h03;
            12'h663: v = 8'h70;
            12'h6F4: v = 8'h03;
            12'h730: v = 8'h01;
            12'h761: v = 8'h60;
            12'h770: v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Power-on value of a global register.
    function automatic logic [7:0] glb_default(input logic [5:0] i);
        logic [7:0] v;
        v = 8'h00;
        case (i)
            6'h03:   v = 8'h03;
            6'h20:   v = 8'h03;
            6'h21:   v = 8'h01;
            6'h24:   v = 8'h04;
            6'h26:   v = 8'hF0;
            6'h27:   v = 8'h03;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Slot order: floppy, parallel, serial A, serial B.
    function automatic logic [3:0] slot_dev(input logic [1:0] slot);
        logic [3:0] d;
        d = 4'd0;
        case (slot)
            2'd0:    d = 4'd0;
            2'd1:    d = 4'd3;
            2'd2:    d = 4'd4;
            default: d = 4'd5;
        endcase
        return d;
    endfunction

    // Clamp a masked base address to the device's valid port list.
    function automatic logic [11:0] snap_base(input logic [1:0] slot, input logic [11:0] p);
        logic        ok;
        logic [11:0] dflt;
        logic        ser_ok;
        ser_ok = (p == PORT_COM0) || (p == PORT_COM1) || (p == PORT_COM2) ||
                 (p == PORT_COM3) || (p == PORT_COM4) || (p == PORT_COM5) ||
                 (p == PORT_COM6) || (p == PORT_COM7) || (p == PORT_COM8);
        case (slot)
            2'd0:
            begin
                ok   = (p == PORT_FDC0) || (p == PORT_FDC1);
                dflt = PORT_FDC0;
            end
            2'd1:
            begin
                ok   = (p == PORT_LPT0) || (p == PORT_LPT1) || (p == PORT_LPT2);
                dflt = PORT_LPT1;
            end
            2'd2:
            begin
                ok   = ser_ok;
                dflt = PORT_COM0;
            end
            default:
            begin
                ok   = ser_ok;
                dflt = PORT_COM1;
            end
        endcase
        if (p[11:8] == 4'h0 || !ok)
        begin
            return dflt;
        end
        return p;
    endfunction

endpackage

// ===== hdl/sio_cfg_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sio_cfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/superio_config_register_file.sv =====
// Index/data configuration register file of a plug-and-play Super I/O chip.
// The accepted access is staged with the registered memory read; ST_RESP then loads the output word.
// No new access is taken in ST_RESP, while the registered read of the register memories completes.
// A new access is taken while the previous result is being handed off on the output side.
// Reset: config mode off, index 0; then a clearing pass over all NUM_DEVICES*256 addresses
// (2560 by default) loads the power-on defaults into both memories, in_ready held low.
module superio_config_register_file #(
    parameter int NUM_DEVICES = 10
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic        addr_bit,
    input  logic [7:0]  wdata,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        pass_through,
    output logic [1:0]  dev_event,
    output logic [2:0]  dev_id,
    output logic [11:0] base_port,
    output logic [7:0]  irq_line,
    output logic        os2_mode,
    output logic        drive_swap,
    output logic [1:0]  density_force,
    output logic [1:0]  density_polarity,
    output logic [3:0]  drive_rates
);

    localparam int DEV_W     = $clog2(NUM_DEVICES);
    localparam int DEV_DEPTH = NUM_DEVICES * sio_cfg_pkg::REGS_PER_DEVICE;
    localparam int DEV_AW    = $clog2(DEV_DEPTH);
    localparam int GLB_AW    = $clog2(sio_cfg_pkg::NUM_GLOBAL_REGS);
    localparam int NS        = sio_cfg_pkg::NUM_SLOTS;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    sio_cfg_pkg::ctl_state_t state_reg, state_next;
    logic [DEV_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_last;

    logic       cfg_mode_reg, cfg_mode_next;
    logic       armed_reg, armed_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] ldn_reg, ldn_next;    // copy of global register 7 (device select)

    // Live copies of activate, base and IRQ registers of floppy, parallel and
    // both serial ports. Reads of these registers come from here, since a base
    // snap rewrites two registers at once.
    logic [7:0] act_reg [NS];
    logic [7:0] hi_reg  [NS];
    logic [7:0] lo_reg  [NS];
    logic [7:0] irq_reg [NS];
    logic [7:0] act_next [NS];
    logic [7:0] hi_next  [NS];
    logic [7:0] lo_next  [NS];
    logic [7:0] irq_next [NS];

    // Floppy mode bits from device 0 registers 0xF0, 0xF1, 0xF4, 0xF5.
    logic       os2_reg, os2_next;
    logic       swap_reg, swap_next;
    logic [3:0] f1_reg, f1_next;      // register 0xF1 bits 5:2
    logic [1:0] rate0_reg, rate0_next;
    logic [1:0] rate1_reg, rate1_next;

    // Staged result of the accepted access, finished in ST_RESP.
    sio_cfg_pkg::rd_src_t src_reg, src_next;
    logic [7:0]  imm_reg, imm_next;
    logic        pass_reg, pass_next;
    logic [1:0]  ev_reg, ev_next;
    logic [2:0]  evdev_reg, evdev_next;
    logic [11:0] base_reg, base_next;
    logic [7:0]  irqo_reg, irqo_next;

    // Output word register.
    logic        out_valid_reg;
    logic [7:0]  rd_out_reg;
    logic        pass_out_reg;
    logic [1:0]  ev_out_reg;
    logic [2:0]  evdev_out_reg;
    logic [11:0] base_out_reg;
    logic [7:0]  irq_out_reg;

    logic acc;
    logic init_phase;
    logic resp_load;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic              glb_we;
    logic [GLB_AW-1:0] glb_waddr;
    logic [7:0]        glb_wdata;
    logic [7:0]        glb_rdata;
    logic              dev_we;
    logic [DEV_AW-1:0] dev_waddr;
    logic [7:0]        dev_wdata;
    logic [7:0]        dev_rdata;
    logic              item_glb_we;
    logic              item_dev_we;

    sio_cfg_ram #(
        .WIDTH (8),
        .DEPTH (sio_cfg_pkg::NUM_GLOBAL_REGS)
    ) u_glb_ram (
        .clk   (clk),
        .we    (glb_we),
        .waddr (glb_waddr),
        .wdata (glb_wdata),
        .raddr (idx_reg[GLB_AW-1:0]),
        .rdata (glb_rdata)
    );

    sio_cfg_ram #(
        .WIDTH (8),
        .DEPTH (DEV_DEPTH)
    ) u_dev_ram (
        .clk   (clk),
        .we    (dev_we),
        .waddr (dev_waddr),
        .wdata (dev_wdata),
        .raddr ({ldn_reg[DEV_W-1:0], idx_reg}),
        .rdata (dev_rdata)
    );

    // Clearing pass owns both write ports until it ends.
    always_comb
    begin
        if (init_phase)
        begin
            glb_we    = (clr_cnt_reg < DEV_AW'(sio_cfg_pkg::NUM_GLOBAL_REGS));
            glb_waddr = clr_cnt_reg[GLB_AW-1:0];
            glb_wdata = sio_cfg_pkg::glb_default(clr_cnt_reg[GLB_AW-1:0]);
            dev_we    = 1'b1;
            dev_waddr = clr_cnt_reg;
            dev_wdata = sio_cfg_pkg::dev_default(4'(clr_cnt_reg[DEV_AW-1:8]),
                                                 clr_cnt_reg[7:0]);
        end
        else
        begin
            glb_we    = item_glb_we;
            glb_waddr = idx_reg[GLB_AW-1:0];
            glb_wdata = wdata;
            dev_we    = item_dev_we;
            dev_waddr = {ldn_reg[DEV_W-1:0], idx_reg};
            dev_wdata = wdata;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and outputs
    // ------------------------------------------------------------------
    assign clr_last = (clr_cnt_reg == DEV_AW'(DEV_DEPTH - 1));
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sio_cfg_pkg::ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = sio_cfg_pkg::ST_IDLE;
                end
            end
            sio_cfg_pkg::ST_IDLE:
            begin
                if (in_valid && (!out_valid_reg || out_ready))
                begin
                    state_next = sio_cfg_pkg::ST_RESP;
                end
            end
            sio_cfg_pkg::ST_RESP:
            begin
                state_next = sio_cfg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sio_cfg_pkg::ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        init_phase = 1'b0;
        resp_load  = 1'b0;
        unique case (state_reg)
            sio_cfg_pkg::ST_INIT: init_phase = 1'b1;
            sio_cfg_pkg::ST_IDLE: in_ready   = !out_valid_reg || out_ready;
            sio_cfg_pkg::ST_RESP: resp_load  = 1'b1;
            default:              init_phase = 1'b0;
        endcase
    end

    assign clr_cnt_next = init_phase ? clr_cnt_reg + DEV_AW'(1) : clr_cnt_reg;

    // ------------------------------------------------------------------
    // Access decode
    // ------------------------------------------------------------------
    logic [1:0] slot;
    logic       slot_hit;
    logic       sh_sel;
    logic [7:0] sh_old;
    logic       dev_write_ok;
    logic       serial;

    // Only floppy, parallel and the serial ports accept device writes.
    always_comb
    begin
        slot     = 2'd0;
        slot_hit = 1'b1;
        case (ldn_reg)
            8'd0:    slot = 2'd0;
            8'd3:    slot = 2'd1;
            8'd4:    slot = 2'd2;
            8'd5:    slot = 2'd3;
            default: slot_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        sh_sel = 1'b1;
        sh_old = 8'h00;
        case (idx_reg)
            sio_cfg_pkg::REG_ACT:     sh_old = act_reg[slot];
            sio_cfg_pkg::REG_BASE_HI: sh_old = hi_reg[slot];
            sio_cfg_pkg::REG_BASE_LO: sh_old = lo_reg[slot];
            sio_cfg_pkg::REG_IRQ:     sh_old = irq_reg[slot];
            default:                  sh_sel = 1'b0;
        endcase
    end

    // IRQ block (0x70-0x7F) is read-only on floppy and parallel.
    assign dev_write_ok = slot_hit && !(idx_reg[7:4] == 4'h7 && ldn_reg < 8'd4);
    assign serial       = (slot == 2'd2) || (slot == 2'd3);

    always_comb
    begin
        logic [7:0]  act_n;
        logic [7:0]  hi_n;
        logic [7:0]  lo_n;
        logic [7:0]  irq_n;
        logic        is_act;
        logic        is_recfg;
        logic [11:0] snapped;

        act_n    = act_reg[slot];
        hi_n     = hi_reg[slot];
        lo_n     = lo_reg[slot];
        irq_n    = irq_reg[slot];
        is_act   = (idx_reg == sio_cfg_pkg::REG_ACT);
        is_recfg = (idx_reg == sio_cfg_pkg::REG_BASE_HI) ||
                   (idx_reg == sio_cfg_pkg::REG_BASE_LO) ||
                   (serial && idx_reg == sio_cfg_pkg::REG_IRQ);
        snapped  = 12'h000;

        cfg_mode_next = cfg_mode_reg;
        armed_next    = armed_reg;
        idx_next      = idx_reg;
        ldn_next      = ldn_reg;
        os2_next      = os2_reg;
        swap_next     = swap_reg;
        f1_next       = f1_reg;
        rate0_next    = rate0_reg;
        rate1_next    = rate1_reg;
        for (int s = 0; s < NS; s++)
        begin
            act_next[s] = act_reg[s];
            hi_next[s]  = hi_reg[s];
            lo_next[s]  = lo_reg[s];
            irq_next[s] = irq_reg[s];
        end

        src_next    = sio_cfg_pkg::SRC_IMM;
        imm_next    = 8'h00;
        pass_next   = 1'b0;
        ev_next     = sio_cfg_pkg::EV_NONE;
        evdev_next  = 3'd0;
        base_next   = 12'h000;
        irqo_next   = 8'h00;
        item_glb_we = 1'b0;
        item_dev_we = 1'b0;

        if (acc)
        begin
            if (!op)
            begin
                if (!cfg_mode_reg)
                begin
                    pass_next = 1'b1;
                end
                else if (!addr_bit)
                begin
                    imm_next = idx_reg;
                end
                else if (idx_reg < 8'(sio_cfg_pkg::NUM_GLOBAL_REGS))
                begin
                    src_next = sio_cfg_pkg::SRC_GLB;
                end
                else if (ldn_reg < 8'(NUM_DEVICES))
                begin
                    if (slot_hit && sh_sel)
                    begin
                        imm_next = sh_old;
                    end
                    else
                    begin
                        src_next = sio_cfg_pkg::SRC_DEV;
                    end
                end
            end
            else if (!addr_bit)
            begin
                // Unlock key pair / lock key / index select.
                if (wdata == sio_cfg_pkg::UNLOCK_KEY && !cfg_mode_reg)
                begin
                    if (armed_reg)
                    begin
                        cfg_mode_next = 1'b1;
                        armed_next    = 1'b0;
                    end
                    else
                    begin
                        armed_next = 1'b1;
                    end
                end
                else if (cfg_mode_reg)
                begin
                    if (wdata == sio_cfg_pkg::LOCK_KEY)
                    begin
                        cfg_mode_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = wdata;
                    end
                end
                else
                begin
                    armed_next = 1'b0;
                end
            end
            else if (cfg_mode_reg)
            begin
                if (idx_reg < 8'(sio_cfg_pkg::NUM_GLOBAL_REGS))
                begin
                    item_glb_we = 1'b1;
                    if (idx_reg == sio_cfg_pkg::GLB_LDN)
                    begin
                        ldn_next = wdata;
                    end
                end
                else if (dev_write_ok)
                begin
                    item_dev_we = 1'b1;
                    if (slot == 2'd0)
                    begin
                        case (idx_reg)
                            sio_cfg_pkg::REG_FDD_F0:
                            begin
                                os2_next  = wdata[0];
                                swap_next = wdata[4];
                            end
                            sio_cfg_pkg::REG_FDD_F1: f1_next    = wdata[5:2];
                            sio_cfg_pkg::REG_FDD_F4: rate0_next = wdata[4:3];
                            sio_cfg_pkg::REG_FDD_F5: rate1_next = wdata[4:3];
                            default: ;
                        endcase
                    end
                    if (sh_sel)
                    begin
                        case (idx_reg)
                            sio_cfg_pkg::REG_ACT:     act_n = wdata;
                            sio_cfg_pkg::REG_BASE_HI: hi_n  = wdata;
                            sio_cfg_pkg::REG_BASE_LO: lo_n  = wdata;
                            default:                  irq_n = wdata;
                        endcase
                        if (wdata != sh_old)
                        begin
                            if (is_act && wdata == 8'h00)
                            begin
                                ev_next    = sio_cfg_pkg::EV_DISABLE;
                                evdev_next = ldn_reg[2:0];
                            end
                            else if (is_act || (is_recfg && act_n != 8'h00))
                            begin
                                snapped    = sio_cfg_pkg::snap_base(slot,
                                                 {hi_n[3:0], lo_n[7:3], 3'b000});
                                hi_n       = {4'h0, snapped[11:8]};
                                lo_n       = snapped[7:0];
                                ev_next    = sio_cfg_pkg::EV_ENABLE;
                                evdev_next = ldn_reg[2:0];
                                base_next  = snapped;
                                irqo_next  = serial ? irq_n : 8'h00;
                            end
                        end
                        act_next[slot] = act_n;
                        hi_next[slot]  = hi_n;
                        lo_next[slot]  = lo_n;
                        irq_next[slot] = irq_n;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sio_cfg_pkg::ST_INIT;
            clr_cnt_reg  <= '0;
            cfg_mode_reg <= 1'b0;
            armed_reg    <= 1'b0;
            idx_reg      <= 8'h00;
            ldn_reg      <= 8'h00;
            os2_reg      <= 1'b0;
            swap_reg     <= 1'b0;
            f1_reg       <= 4'h0;
            rate0_reg    <= 2'd0;
            rate1_reg    <= 2'd0;
            for (int s = 0; s < NS; s++)
            begin
                act_reg[s] <= sio_cfg_pkg::dev_default(sio_cfg_pkg::slot_dev(2'(s)),
                                                       sio_cfg_pkg::REG_ACT);
                hi_reg[s]  <= sio_cfg_pkg::dev_default(sio_cfg_pkg::slot_dev(2'(s)),
                                                       sio_cfg_pkg::REG_BASE_HI);
                lo_reg[s]  <= sio_cfg_pkg::dev_default(sio_cfg_pkg::slot_dev(2'(s)),
                                                       sio_cfg_pkg::REG_BASE_LO);
                irq_reg[s] <= sio_cfg_pkg::dev_default(sio_cfg_pkg::slot_dev(2'(s)),
                                                       sio_cfg_pkg::REG_IRQ);
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            cfg_mode_reg <= cfg_mode_next;
            armed_reg    <= armed_next;
            idx_reg      <= idx_next;
            ldn_reg      <= ldn_next;
            os2_reg      <= os2_next;
            swap_reg     <= swap_next;
            f1_reg       <= f1_next;
            rate0_reg    <= rate0_next;
            rate1_reg    <= rate1_next;
            for (int s = 0; s < NS; s++)
            begin
                act_reg[s] <= act_next[s];
                hi_reg[s]  <= hi_next[s];
                lo_reg[s]  <= lo_next[s];
                irq_reg[s] <= irq_next[s];
            end
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Staging and output payload.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            src_reg   <= src_next;
            imm_reg   <= imm_next;
            pass_reg  <= pass_next;
            ev_reg    <= ev_next;
            evdev_reg <= evdev_next;
            base_reg  <= base_next;
            irqo_reg  <= irqo_next;
        end
        if (resp_load)
        begin
            case (src_reg)
                sio_cfg_pkg::SRC_GLB: rd_out_reg <= glb_rdata;
                sio_cfg_pkg::SRC_DEV: rd_out_reg <= dev_rdata;
                default:              rd_out_reg <= imm_reg;
            endcase
            pass_out_reg  <= pass_reg;
            ev_out_reg    <= ev_reg;
            evdev_out_reg <= evdev_reg;
            base_out_reg  <= base_reg;
            irq_out_reg   <= irqo_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = rd_out_reg;
    assign pass_through     = pass_out_reg;
    assign dev_event        = ev_out_reg;
    assign dev_id           = evdev_out_reg;
    assign base_port        = base_out_reg;
    assign irq_line         = irq_out_reg;
    // Mode bits hold still while a word waits: they only move on an accept.
    assign os2_mode         = os2_reg;
    assign drive_swap       = swap_reg;
    assign density_force    = f1_reg[1:0];
    assign density_polarity = ~f1_reg[3:2];
    assign drive_rates      = {rate1_reg, rate0_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##2 out_valid)
        else $error("result word not presented two cycles after accept");

    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_phase |-> !in_ready && !item_dev_we && !item_glb_we)
        else $error("access taken during clearing pass");

    a_event_device: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dev_event != sio_cfg_pkg::EV_NONE) |->
            (dev_id == 3'd0 || dev_id == 3'd3 || dev_id == 3'd4 || dev_id == 3'd5))
        else $error("event reported for a device without base logic");

    a_enable_base: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dev_event == sio_cfg_pkg::EV_ENABLE) |-> base_port[11:8] != 4'h0)
        else $error("enable event with unsnapped base");

    a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pass_through) |->
            (read_data == 8'h00 && dev_event == sio_cfg_pkg::EV_NONE))
        else $error("pass-through word carries data or an event");

endmodule
